>>> rtl/sacad_pkg.sv
// shared types and constants for the sort and duplicate count block
package sacad_pkg;

	localparam int CAPACITY = 32;
	localparam int VALUE_W  = 32;
	localparam int PAIR_W   = 5;
	localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_in;
		logic                      last_in;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      equals_next;
		logic [PAIR_W-1:0]         pair_count;
		logic                      overflow;
		logic                      last_out;
	} result_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                      insert;
		logic                      drain;
		logic signed [VALUE_W-1:0] value;
	} cell_ctrl_t;

endpackage

>>> rtl/sacad_cell.sv
// one cell of the sorted insertion chain
module sacad_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sacad_pkg::cell_ctrl_t              ctrl,
	input  logic                               left_gt,
	input  logic                               left_valid,
	input  logic signed [sacad_pkg::VALUE_W-1:0] left_value,
	input  logic                               right_valid,
	input  logic signed [sacad_pkg::VALUE_W-1:0] right_value,
	output logic                               valid,
	output logic signed [sacad_pkg::VALUE_W-1:0] value,
	output logic                               gt
);

	logic                                  valid_q;
	logic signed [sacad_pkg::VALUE_W-1:0]  value_q;

	// empty cell acts as plus infinity
	assign gt    = !valid_q || (value_q > ctrl.value);
	assign valid = valid_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | left_valid;
		end else if (ctrl.drain) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && gt) begin
			value_q <= left_gt ? left_value : ctrl.value;
		end else if (ctrl.drain) begin
			value_q <= right_value;
		end
	end

endmodule

>>> rtl/sort_and_count_adjacent_duplicates_core.sv
// top level: insertion-sort cell chain with ordered unload and pair counting
//
// values enter one beat per cycle on the item channel and are placed at once
// into a chain of CAPACITY cells kept in ascending signed order; there is no
// load stall while loading. the beat with last_in set ends the set: once the
// sequencer is in its unload state the chain shifts toward cell 0 and one
// result beat leaves per cycle (slower if result_stall is held), n results
// for n stored values. while a set unloads item_stall is high, so no new
// value is taken until it has left. a value that arrives with the chain full
// is dropped and every result of that set carries overflow. equals_next flags
// a value equal to its successor; pair_count, valid on the last_out beat,
// counts such pairs and saturates at its maximum, and is zero on other beats.
module sort_and_count_adjacent_duplicates_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  sacad_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output sacad_pkg::result_t  result
);

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                                  state_q;
	logic                                  overflow_q;
	logic [sacad_pkg::PAIR_W-1:0]          pairs_q;
	logic                                  result_valid_q;
	sacad_pkg::result_t                    result_q;

	sacad_pkg::cell_ctrl_t                 ctrl;
	logic [sacad_pkg::CAPACITY-1:0]        cell_valid;
	logic [sacad_pkg::CAPACITY-1:0]        cell_gt;
	logic signed [sacad_pkg::VALUE_W-1:0]  cell_value [sacad_pkg::CAPACITY];

	logic                                  accept;
	logic                                  full;
	logic                                  take;
	logic                                  head_eq;
	logic                                  head_last;
	logic [sacad_pkg::PAIR_W-1:0]          pairs_next;

	// handshake
	assign item_stall   = (state_q == ST_DRAIN);
	assign accept       = item_valid && !item_stall;
	assign full         = cell_valid[sacad_pkg::CAPACITY-1];
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// unload one cell when the output register is free or being emptied
	assign take = (state_q == ST_DRAIN) && (!result_valid_q || !result_stall);

	assign ctrl.insert = accept && !full;
	assign ctrl.drain  = take;
	assign ctrl.value  = item.value_in;

	// the cell chain
	for (genvar i = 0; i < sacad_pkg::CAPACITY; i++) begin : g_cell
		logic                                 l_gt;
		logic                                 l_valid;
		logic signed [sacad_pkg::VALUE_W-1:0] l_value;
		logic                                 r_valid;
		logic signed [sacad_pkg::VALUE_W-1:0] r_value;

		if (i == 0) begin : g_head
			// head always fills on insert; nothing to its left is larger
			assign l_gt    = 1'b0;
			assign l_valid = 1'b1;
			assign l_value = '0;
		end else begin : g_body
			assign l_gt    = cell_gt[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_value = cell_value[i-1];
		end

		if (i == sacad_pkg::CAPACITY - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_value = '0;
		end else begin : g_inner
			assign r_valid = cell_valid[i+1];
			assign r_value = cell_value[i+1];
		end

		sacad_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_gt     (l_gt),
			.left_valid  (l_valid),
			.left_value  (l_value),
			.right_valid (r_valid),
			.right_value (r_value),
			.valid       (cell_valid[i]),
			.value       (cell_value[i]),
			.gt          (cell_gt[i])
		);
	end

	// head of chain compared with its successor
	assign head_last = !cell_valid[1];
	assign head_eq   = cell_valid[1] && (cell_value[0] == cell_value[1]);

	always_comb begin
		if (head_eq && (pairs_q != sacad_pkg::PAIR_MAX)) begin
			pairs_next = pairs_q + 1'b1;
		end else begin
			pairs_next = pairs_q;
		end
	end

	// sequencer, overflow flag and pair counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			overflow_q <= 1'b0;
			pairs_q    <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							overflow_q <= 1'b1;
						end
						if (item.last_in) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (take) begin
						if (head_last) begin
							state_q    <= ST_LOAD;
							overflow_q <= 1'b0;
							pairs_q    <= '0;
						end else begin
							pairs_q <= pairs_next;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q.sorted_value <= cell_value[0];
			result_q.equals_next  <= head_eq;
			result_q.pair_count   <= head_last ? pairs_next : '0;
			result_q.overflow     <= overflow_q;
			result_q.last_out     <= head_last;
		end
	end

	// occupied cells always form a solid run starting at the head
	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid >> 1) & ~cell_valid) == '0)
		else $error("gap in occupied cells");

	// unloading never starts or runs on an empty chain
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> cell_valid[0])
		else $error("unload with empty chain");

	// after the final cell leaves, the set state is back to its start
	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head_last) |=> (cell_valid == '0 && pairs_q == '0 && !overflow_q
			&& state_q == ST_LOAD))
		else $error("set state not cleared after final result");

	// a last_out beat is produced only from the final occupied cell
	a_last_from_tail: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (result_q.last_out == (cell_valid == '0)))
		else $error("last_out disagrees with chain contents");

endmodule

>>> verif/tb_sort_and_count_adjacent_duplicates_core.sv
// testbench for the sort and adjacent duplicate count block, checked against a sorted-set model
module tb_sort_and_count_adjacent_duplicates_core;

	typedef logic signed [sacad_pkg::VALUE_W-1:0] value_t;

	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AFTER   = 90;
	localparam int RANDOM_ITEMS = 190;
	localparam int QUIET_AFTER  = 150;
	localparam int DRAIN_CYCLES = 2 * sacad_pkg::CAPACITY + 8;

	// keeps the set as it is being loaded, sorted, and the result beats it will unload into
	class sort_scoreboard;
		value_t             sorted_set[$];
		bit                 dropped;
		sacad_pkg::result_t pending[$];
		int                 errors;

		// insert after equal values, or drop when the store is full; last_in unloads the set
		function void note_item(sacad_pkg::item_t it);
			int                           pos;
			int                           n;
			logic [sacad_pkg::PAIR_W-1:0] pairs;
			sacad_pkg::result_t           r;
			if (sorted_set.size() < sacad_pkg::CAPACITY) begin
				pos = sorted_set.size();
				while (pos > 0 && sorted_set[pos-1] > value_t'(it.value_in))
					pos--;
				sorted_set.insert(pos, value_t'(it.value_in));
			end else begin
				dropped = 1'b1;
			end
			if (!it.last_in)
				return;
			n = sorted_set.size();
			pairs = '0;
			for (int i = 0; i < n; i++) begin
				r.sorted_value = sorted_set[i];
				r.equals_next  = (i + 1 < n) && (sorted_set[i] == sorted_set[i+1]);
				if (r.equals_next && pairs < sacad_pkg::PAIR_MAX)
					pairs++;
				r.last_out   = (i + 1 == n);
				r.pair_count = r.last_out ? pairs : '0;
				r.overflow   = dropped;
				pending.push_back(r);
			end
			sorted_set.delete();
			dropped = 1'b0;
		endfunction

		function void check_result(sacad_pkg::result_t got);
			sacad_pkg::result_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: sorted_value %0d",
					got.sorted_value);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.sorted_value !== want.sorted_value) begin
				$error("sorted_value expected %0d actual %0d",
					want.sorted_value, got.sorted_value);
				errors++;
			end
			if (got.equals_next !== want.equals_next) begin
				$error("equals_next expected %0b actual %0b",
					want.equals_next, got.equals_next);
				errors++;
			end
			if (got.pair_count !== want.pair_count) begin
				$error("pair_count expected %0d actual %0d",
					want.pair_count, got.pair_count);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow expected %0b actual %0b", want.overflow, got.overflow);
				errors++;
			end
			if (got.last_out !== want.last_out) begin
				$error("last_out expected %0b actual %0b", want.last_out, got.last_out);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	sacad_pkg::item_t   item;
	logic               result_valid;
	logic               result_stall;
	sacad_pkg::result_t result;

	sort_scoreboard sorted_sets = new();
	int             items_taken;
	bit             quiet;
	bit             held_long;

	sort_and_count_adjacent_duplicates_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// both channels are observed at the rising edge; inputs are noted before results are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				sorted_sets.note_item(item);
				items_taken++;
			end
			if (result_valid && !result_stall)
				sorted_sets.check_result(result);
		end
	end

	// receiver: random stall bursts, one long hold-off to back the block up, none when quiet
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && !held_long && items_taken >= HOLD_AFTER) begin
				held_long = 1'b1;
				result_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	task automatic send_beat(input value_t v, input logic last);
		sacad_pkg::item_t it;
		it.value_in = v;
		it.last_in  = last;
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// payload wanders while valid is low
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		item_valid <= 1'b0;
		item       <= sacad_pkg::item_t'({$urandom, 1'($urandom)});
		repeat (cycles - 1) @(negedge clk);
	endtask

	// one set, last_in on its final beat
	task automatic load_set(input value_t vals[$]);
		foreach (vals[i]) begin
			if (!quiet && $urandom_range(0, 5) == 0)
				pause_sender($urandom_range(1, 14));
			send_beat(vals[i], i == vals.size() - 1);
		end
	endtask

	function automatic value_t pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return value_t'($urandom);
		if (sel < 8)
			return value_t'(int'($urandom_range(0, 7)) - 4);
		if (sel == 8)
			return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		return $urandom_range(0, 1) ? 32'sh8000_0001 : 32'sh7FFF_FFFE;
	endfunction

	initial begin
		value_t      vals[$];
		value_t      same;
		int          sent;
		int          set_no;
		int          len;
		int unsigned kind;

		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single value, field extremes, duplicates, both signs
		load_set('{32'sh7FFF_FFFF});
		load_set('{32'sh8000_0000});
		load_set('{-32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd1});
		load_set('{32'sd5, 32'sd5, -32'sd3, 32'sd5, -32'sd3});
		load_set('{32'sh8000_0000, 32'sh8000_0000});
		load_set('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, -32'sd1, 32'sd0});

		// random sets: first a full store of one value plus a dropped last beat,
		// then exactly capacity, then mostly short sets with the odd overflow
		sent = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			vals.delete();
			if (set_no == 0) begin
				same = pick_value();
				repeat (sacad_pkg::CAPACITY + 1) vals.push_back(same);
			end else begin
				kind = $urandom_range(0, 9);
				if (set_no == 1)
					len = sacad_pkg::CAPACITY;
				else if (kind < 7)
					len = $urandom_range(1, 8);
				else if (kind < 9)
					len = $urandom_range(9, sacad_pkg::CAPACITY - 1);
				else
					len = $urandom_range(sacad_pkg::CAPACITY, sacad_pkg::CAPACITY + 8);
				repeat (len) vals.push_back(pick_value());
			end
			load_set(vals);
			sent += vals.size();
			set_no++;
			if (sent >= QUIET_AFTER)
				quiet = 1'b1;
		end

		@(negedge clk);
		item_valid <= 1'b0;

		while (sorted_sets.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sorted_sets.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
rtl/sacad_pkg.sv
rtl/sacad_cell.sv
rtl/sort_and_count_adjacent_duplicates_core.sv
verif/tb_sort_and_count_adjacent_duplicates_core.sv
